[hdl/gdb_pkg.sv]
// ----------------------------------------------------------------------------
// gdb_pkg: shared types and constants
// cell data types, arctangent table and fixed-point helpers for the
// distance and bearing pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package gdb_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_STEPS    = 32;
  localparam int LAT           = 2 * CORDIC_STAGES + SQRT_STEPS + 7;
  localparam int BRG_DLY       = SQRT_STEPS + 2;

  localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic [30:0]        DEG7_TO_BANG = 31'd1281023894;
  localparam logic [30:0]        PI_Q29    = 31'd1686629713;
  localparam logic [25:0]        DEG5_TURN = 26'd36000000;
  localparam logic [29:0]        RADIUS_CM_RST = 30'd637100000;
  localparam logic [6:0]         M_TO_CM   = 7'd100;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [33:0] z;
    logic               zero;
  } vec_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sqrt_t;

  function automatic logic [30:0] atan_val(input logic [4:0] i);
    logic [30:0] t;
    unique case (i)
      5'd0:  t = 31'd536870912;
      5'd1:  t = 31'd316933406;
      5'd2:  t = 31'd167458907;
      5'd3:  t = 31'd85004756;
      5'd4:  t = 31'd42667331;
      5'd5:  t = 31'd21354465;
      5'd6:  t = 31'd10679838;
      5'd7:  t = 31'd5340245;
      5'd8:  t = 31'd2670163;
      5'd9:  t = 31'd1335087;
      5'd10: t = 31'd667544;
      5'd11: t = 31'd333772;
      5'd12: t = 31'd166886;
      5'd13: t = 31'd83443;
      5'd14: t = 31'd41722;
      5'd15: t = 31'd20861;
      5'd16: t = 31'd10430;
      5'd17: t = 31'd5215;
      5'd18: t = 31'd2608;
      5'd19: t = 31'd1304;
      5'd20: t = 31'd652;
      5'd21: t = 31'd326;
      5'd22: t = 31'd163;
      5'd23: t = 31'd81;
      5'd24: t = 31'd41;
      5'd25: t = 31'd20;
      5'd26: t = 31'd10;
      5'd27: t = 31'd5;
      5'd28: t = 31'd3;
      5'd29: t = 31'd1;
      5'd30: t = 31'd1;
      5'd31: t = 31'd0;
    endcase
    return t;
  endfunction

  // degrees * 1e7 to binary angle, rounded half away from zero
  function automatic logic [31:0] deg7_to_bang(input logic signed [31:0] d);
    logic [31:0] m;
    logic [63:0] p;
    m = d[31] ? 32'(-d) : 32'(d);
    p = (64'(m) * 64'(DEG7_TO_BANG) + 64'd536870912) >> 30;
    return d[31] ? 32'(-p[31:0]) : p[31:0];
  endfunction

  // fold binary angle into the half turn around zero
  function automatic rot_t fold(input logic [31:0] a);
    rot_t o;
    logic signed [33:0] z;
    z = 34'(signed'(a));
    o.x = GAIN_Q30;
    o.y = '0;
    o.flip = 1'b0;
    if (z >= ONE_Q30) begin
      z = z - 2 * ONE_Q30;
      o.flip = 1'b1;
    end else if (z < -ONE_Q30) begin
      z = z + 2 * ONE_Q30;
      o.flip = 1'b1;
    end
    o.z = z;
    return o;
  endfunction

  function automatic logic signed [35:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return 36'(p >>> 30);
  endfunction

endpackage
`default_nettype wire

[hdl/gdb_rot_cell.sv]
// ----------------------------------------------------------------------------
// gdb_rot_cell: rotation cordic cell
// one micro-rotation of the sin/cos chain, registered
// ----------------------------------------------------------------------------
`default_nettype none
module gdb_rot_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    idx,
  input  gdb_pkg::rot_t d_i,
  output gdb_pkg::rot_t d_o
);
  import gdb_pkg::*;

  rot_t d_r, d_nxt;
  logic signed [33:0] x, y, z, dx, dy, at;

  always_comb begin
    x  = d_i.x;
    y  = d_i.y;
    z  = d_i.z;
    dx = y >>> idx;
    dy = x >>> idx;
    at = 34'(atan_val(idx));
    d_nxt.flip = d_i.flip;
    if (z >= 0) begin
      d_nxt.x = x - dx;
      d_nxt.y = y + dy;
      d_nxt.z = z - at;
    end else begin
      d_nxt.x = x + dx;
      d_nxt.y = y - dy;
      d_nxt.z = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

[hdl/gdb_vec_cell.sv]
// ----------------------------------------------------------------------------
// gdb_vec_cell: vectoring cordic cell
// one micro-rotation of an atan2 chain, registered
// ----------------------------------------------------------------------------
`default_nettype none
module gdb_vec_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    idx,
  input  gdb_pkg::vec_t d_i,
  output gdb_pkg::vec_t d_o
);
  import gdb_pkg::*;

  vec_t d_r, d_nxt;
  logic signed [35:0] x, y, dx, dy;
  logic signed [33:0] z, at;

  always_comb begin
    x  = d_i.x;
    y  = d_i.y;
    z  = d_i.z;
    dx = y >>> idx;
    dy = x >>> idx;
    at = 34'(atan_val(idx));
    d_nxt.zero = d_i.zero;
    if (y >= 0) begin
      d_nxt.x = x + dx;
      d_nxt.y = y - dy;
      d_nxt.z = z + at;
    end else begin
      d_nxt.x = x - dx;
      d_nxt.y = y + dy;
      d_nxt.z = z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

[hdl/gdb_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// gdb_sqrt_cell: square root cell
// one digit of the integer square root recurrence, registered
// ----------------------------------------------------------------------------
`default_nettype none
module gdb_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     idx,
  input  gdb_pkg::sqrt_t d_i,
  output gdb_pkg::sqrt_t d_o
);
  import gdb_pkg::*;

  sqrt_t d_r, d_nxt;
  logic [63:0] b;
  logic [64:0] sum;

  always_comb begin
    b   = 64'd1 << (6'd62 - {idx, 1'b0});
    sum = {1'b0, d_i.r} + {1'b0, b};
    if ({1'b0, d_i.v} >= sum) begin
      d_nxt.v = d_i.v - sum[63:0];
      d_nxt.r = (d_i.r >> 1) + b;
    end else begin
      d_nxt.v = d_i.v;
      d_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

[hdl/gps_distance_and_bearing_unit.sv]
// throughput: one item per cycle unless a stalled result holds it; each cordic and
// square root step is a cell of its own in a registered chain
// a stalled result holds the whole pipeline
// reset (synchronous, active low) empties the pipeline and sets the
// radius to 6371000 m
// ----------------------------------------------------------------------------
// gps_distance_and_bearing_unit: great-circle distance and initial bearing
// haversine distance in cm and compass bearing in 1e-5 degree per item
// ----------------------------------------------------------------------------
`default_nettype none
module gps_distance_and_bearing_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_start_lat,
  input  logic signed [31:0] in_start_lon,
  input  logic signed [30:0] in_end_lat,
  input  logic signed [31:0] in_end_lon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_distance_cm,
  output logic signed [25:0] out_bearing_deg
);
  import gdb_pkg::*;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [29:0] radius_cm_r;

  logic [31:0] bang_r [4];
  rot_t rot_q [4][CORDIC_STAGES+1];
  logic signed [32:0] cq [4];
  logic signed [32:0] sq [4];

  logic signed [35:0] p1_r, ba_r, t1_r, p2_r, hlat_r, hlon_r;
  logic signed [32:0] cdl_r;
  logic signed [35:0] a_r, bb_r, ba2_r;
  logic [30:0] a_cl;

  sqrt_t sa_q [SQRT_STEPS+1];
  sqrt_t sb_q [SQRT_STEPS+1];
  vec_t  bv_q [CORDIC_STAGES+1];
  vec_t  dv_q [CORDIC_STAGES+1];
  vec_t  bv_nxt;

  logic signed [33:0] dz;
  logic [30:0] dz_cl;
  logic [31:0] rad_r;
  logic [61:0] rad_p;
  logic [61:0] dist_p;

  logic signed [31:0] bz;
  logic [31:0] bm;
  logic [57:0] bp;
  logic signed [25:0] brg_dly_r [BRG_DLY];
  logic [31:0] dist_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      radius_cm_r <= RADIUS_CM_RST;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_we) radius_cm_r <= 30'(cfg_wdata) * 30'(M_TO_CM);
    end
  end

  // angle conversion
  always_ff @(posedge clk) begin
    if (en) begin
      bang_r[0] <= deg7_to_bang(32'(in_start_lat));
      bang_r[1] <= deg7_to_bang(32'(in_end_lat));
      bang_r[2] <= deg7_to_bang(in_end_lon) - deg7_to_bang(in_start_lon);
      bang_r[3] <= deg7_to_bang(32'(in_end_lat)) - deg7_to_bang(32'(in_start_lat));
    end
  end

  // lanes: lat1, lat2, dlon, dlat
  genvar l, k;
  generate
    for (l = 0; l < 4; l++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) rot_q[l][0] <= fold(bang_r[l]);
      end
      for (k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        gdb_rot_cell u_cell (
          .clk (clk),
          .en  (en),
          .idx (5'(k)),
          .d_i (rot_q[l][k]),
          .d_o (rot_q[l][k+1])
        );
      end
      assign cq[l] = rot_q[l][CORDIC_STAGES].flip ? 33'(-rot_q[l][CORDIC_STAGES].x)
                                                   : 33'(rot_q[l][CORDIC_STAGES].x);
      assign sq[l] = rot_q[l][CORDIC_STAGES].flip ? 33'(-rot_q[l][CORDIC_STAGES].y)
                                                   : 33'(rot_q[l][CORDIC_STAGES].y);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= mulq(cq[0], cq[1]);
      ba_r   <= mulq(sq[2], cq[1]);
      t1_r   <= mulq(cq[0], sq[1]);
      p2_r   <= mulq(sq[0], cq[1]);
      hlat_r <= (36'(ONE_Q30) - 36'(cq[3])) >>> 1;
      hlon_r <= (36'(ONE_Q30) - 36'(cq[2])) >>> 1;
      cdl_r  <= cq[2];
      a_r    <= hlat_r + mulq(p1_r[32:0], hlon_r[32:0]);
      bb_r   <= t1_r - mulq(p2_r[32:0], cdl_r);
      ba2_r  <= ba_r;
    end
  end

  always_comb begin
    if (a_r < 0) a_cl = '0;
    else if (a_r > 36'(ONE_Q30)) a_cl = 31'(ONE_Q30);
    else a_cl = a_r[30:0];
    bv_nxt.zero = (ba2_r == 0) && (bb_r == 0);
    if (bb_r < 0) begin
      bv_nxt.x = -bb_r;
      bv_nxt.y = -ba2_r;
      bv_nxt.z = 2 * ONE_Q30;
    end else begin
      bv_nxt.x = bb_r;
      bv_nxt.y = ba2_r;
      bv_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_q[0].v <= {3'b0, a_cl, 30'b0};
      sa_q[0].r <= '0;
      sb_q[0].v <= {3'b0, 31'(ONE_Q30) - a_cl, 30'b0};
      sb_q[0].r <= '0;
      bv_q[0]   <= bv_nxt;
    end
  end

  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      gdb_sqrt_cell u_sa (
        .clk (clk), .en (en), .idx (5'(k)), .d_i (sa_q[k]), .d_o (sa_q[k+1])
      );
      gdb_sqrt_cell u_sb (
        .clk (clk), .en (en), .idx (5'(k)), .d_i (sb_q[k]), .d_o (sb_q[k+1])
      );
    end
  endgenerate

  assign dv_q[0].x    = 36'(sb_q[SQRT_STEPS].r[31:0]);
  assign dv_q[0].y    = 36'(sa_q[SQRT_STEPS].r[31:0]);
  assign dv_q[0].z    = '0;
  assign dv_q[0].zero = (sa_q[SQRT_STEPS].r == '0) && (sb_q[SQRT_STEPS].r == '0);

  generate
    for (k = 0; k < CORDIC_STAGES; k++) begin : g_vec
      gdb_vec_cell u_bv (
        .clk (clk), .en (en), .idx (5'(k)), .d_i (bv_q[k]), .d_o (bv_q[k+1])
      );
      gdb_vec_cell u_dv (
        .clk (clk), .en (en), .idx (5'(k)), .d_i (dv_q[k]), .d_o (dv_q[k+1])
      );
    end
  endgenerate

  // distance
  always_comb begin
    dz = dv_q[CORDIC_STAGES].zero ? '0 : dv_q[CORDIC_STAGES].z;
    if (dz < 0) dz_cl = '0;
    else if (dz > ONE_Q30) dz_cl = 31'(ONE_Q30);
    else dz_cl = dz[30:0];
    rad_p  = 62'(dz_cl) * 62'(PI_Q29) + 62'd268435456;
    dist_p = 62'(radius_cm_r) * 62'(rad_r) + 62'd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_p[60:29];
      dist_r <= dist_p[61:30];
    end
  end

  // bearing
  always_comb begin
    bz = bv_q[CORDIC_STAGES].zero ? '0 : bv_q[CORDIC_STAGES].z[31:0];
    bm = bz[31] ? 32'(-bz) : 32'(bz);
    bp = 58'(bm) * 58'(DEG5_TURN) + 58'd2147483648;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brg_dly_r[0] <= bz[31] ? 26'(-bp[57:32]) : 26'(bp[57:32]);
      for (int i = 1; i < BRG_DLY; i++) brg_dly_r[i] <= brg_dly_r[i-1];
    end
  end

  assign out_distance_cm = dist_r;
  assign out_bearing_deg = brg_dly_r[BRG_DLY-1];
endmodule
`default_nettype wire

[test/gps_distance_and_bearing_checker.sv]
// ----------------------------------------------------------------------------
// gps_distance_and_bearing_checker: result predictor and comparator
// watches accepted coordinate items, computes the expected distance and
// bearing in fixed point, and compares each accepted result in order
// ----------------------------------------------------------------------------
`default_nettype none
module gps_distance_and_bearing_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [30:0] in_start_lat,
  input  logic signed [31:0] in_start_lon,
  input  logic signed [30:0] in_end_lat,
  input  logic signed [31:0] in_end_lon,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_distance_cm,
  input  logic signed [25:0] out_bearing_deg,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  import gdb_pkg::*;

  typedef struct packed {
    logic [31:0]        dist_cm;
    logic signed [25:0] brg;
  } leg_t;

  localparam longint TURN_HALF = 64'sd1073741824;
  localparam longint ARC_STEP[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  leg_t   legs_due[$];
  longint radius_m;

  function automatic longint shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] to_bang(longint d);
    longint unsigned m, p;
    m = (d < 0) ? -d : d;
    p = (m * 64'd1281023894 + (64'd1 << 29)) >> 30;
    return (d < 0) ? 32'(-p) : 32'(p);
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(signed'(ang));
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= TURN_HALF) begin
      z -= 2 * TURN_HALF;
      flip = 1;
    end else if (z < -TURN_HALF) begin
      z += 2 * TURN_HALF;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_STEP[i];
      end else begin
        x += dx; y -= dy; z += ARC_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint arc_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 2 * TURN_HALF;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ARC_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ARC_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic leg_t predict_leg(longint la1, longint lo1, longint la2, longint lo2,
                                       longint rad);
    logic [31:0] lat1, lon1, lat2, lon2;
    longint c1, s1, c2, s2, cdl, sdl, cdp, sdp, a, z, ba, bb, bz;
    longint unsigned r, m, dg;
    leg_t o;
    lat1 = to_bang(la1);
    lon1 = to_bang(lo1);
    lat2 = to_bang(la2);
    lon2 = to_bang(lo2);
    rotate(lat1, c1, s1);
    rotate(lat2, c2, s2);
    rotate(lon2 - lon1, cdl, sdl);
    rotate(lat2 - lat1, cdp, sdp);
    a = ((TURN_HALF - cdp) >>> 1) + qmul(qmul(c1, c2), (TURN_HALF - cdl) >>> 1);
    if (a < 0) a = 0;
    if (a > TURN_HALF) a = TURN_HALF;
    z = arc_of(longint'(root_of(a << 30)), longint'(root_of((TURN_HALF - a) << 30)));
    if (z < 0) z = 0;
    if (z > TURN_HALF) z = TURN_HALF;
    r = (longint'(z) * 64'd1686629713 + (64'd1 << 28)) >> 29;
    o.dist_cm = 32'((rad * 100 * r + (64'd1 << 29)) >> 30);
    ba = qmul(sdl, c2);
    bb = qmul(c1, s2) - qmul(qmul(s1, c2), cdl);
    bz = longint'(signed'(32'(arc_of(ba, bb))));
    m = (bz < 0) ? -bz : bz;
    dg = (m * 64'd36000000 + (64'd1 << 31)) >> 32;
    o.brg = 26'((bz < 0) ? -longint'(dg) : longint'(dg));
    return o;
  endfunction

  assign pending = legs_due.size();

  always @(posedge clk) begin
    leg_t e;
    bit   bad;
    bad = 0;
    if (!rst_n) begin
      radius_m <= 6371000;
      errors <= 0;
      checked <= 0;
      legs_due.delete();
    end else begin
      if (cfg_we) radius_m <= cfg_wdata;
      if (in_valid && !in_stall)
        legs_due = {legs_due, predict_leg(in_start_lat, in_start_lon, in_end_lat,
                                          in_end_lon, radius_m)};
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (legs_due.size() == 0) begin
          $error("result with nothing expected: distance %0d bearing %0d",
                 out_distance_cm, out_bearing_deg);
          errors <= errors + 1;
        end else begin
          e = legs_due.pop_front();
          if (out_distance_cm !== e.dist_cm) begin
            $error("distance_cm expected %0d actual %0d", e.dist_cm, out_distance_cm);
            bad = 1;
          end
          if (out_bearing_deg !== e.brg) begin
            $error("bearing_deg expected %0d actual %0d", e.brg, out_bearing_deg);
            bad = 1;
          end
          if (bad) errors <= errors + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[test/gps_distance_and_bearing_unit_tb.sv]
// ----------------------------------------------------------------------------
// gps_distance_and_bearing_unit_tb: testbench top
// drives coordinate items with random gaps and result stalls through several
// earth radius settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none
module gps_distance_and_bearing_unit_tb;
  import gdb_pkg::*;

  localparam int LAT_MAX = 900000000;
  localparam int LON_MAX = 1800000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [22:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [30:0] in_start_lat = '0;
  logic signed [31:0] in_start_lon = '0;
  logic signed [30:0] in_end_lat = '0;
  logic signed [31:0] in_end_lon = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [31:0]        out_distance_cm;
  logic signed [25:0] out_bearing_deg;
  int                 errors, pending, checked;
  bit                 quiet = 0;
  bit                 hold_long = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  gps_distance_and_bearing_unit DUT (.*);
  gps_distance_and_bearing_checker checker_i (.*);

  task automatic send_leg(longint la1, longint lo1, longint la2, longint lo2);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_start_lat <= 31'(la1);
    in_start_lon <= 32'(lo1);
    in_end_lat <= 31'(la2);
    in_end_lon <= 32'(lo2);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic set_radius(logic [22:0] r);
    go_idle();
    cfg_we <= 1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic longint any_lat();
    case ($urandom_range(0, 5))
      0: return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
      1: return longint'(signed'(31'($urandom)));
      default: return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
    endcase
  endfunction

  function automatic longint any_lon();
    if ($urandom_range(0, 5) == 0) return longint'(signed'($urandom));
    return longint'($urandom_range(0, 32'd3600000000)) - LON_MAX;
  endfunction

  task automatic random_legs(int n);
    longint la, lo;
    for (int i = 0; i < n; i++) begin
      la = any_lat();
      lo = any_lon();
      case ($urandom_range(0, 3))
        0: send_leg(la, lo, la + $urandom_range(0, 2000) - 1000,
                    lo + $urandom_range(0, 2000) - 1000);
        1: send_leg(la, lo, -la, lo + LON_MAX);
        default: send_leg(la, lo, any_lat(), any_lon());
      endcase
    end
  endtask

  // result side stalls in random bursts, plus one long hold
  always @(posedge clk) begin
    int cnt;
    if (!rst_n) begin
      cnt = 0;
      out_stall <= 0;
    end else if (hold_long) begin
      out_stall <= 1;
    end else if (quiet) begin
      out_stall <= 0;
    end else if (cnt > 0) begin
      cnt--;
      if (cnt == 0) out_stall <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      cnt = $urandom_range(1, 12);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_leg(0, 0, 0, 0);
    send_leg(LAT_MAX, 0, -LAT_MAX, 0);
    send_leg(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_leg(0, 0, 0, LON_MAX);
    send_leg(0, 0, 0, -LON_MAX);
    send_leg(0, 0, 10, 0);
    send_leg(0, 0, -10, 0);
    send_leg(0, 0, 0, 10);
    send_leg(0, 0, 0, -10);
    send_leg(LAT_MAX, 0, LAT_MAX, 123456789);
    send_leg(-1073741824, -64'sd2147483648, 1073741823, 2147483647);
    send_leg(1073741823, 2147483647, -1073741824, -64'sd2147483648);
    send_leg(-1, -1, -1, -1);
    send_leg(0, 0, 0, 900000000);
    send_leg(377749000, -1224194000, 515074000, -1278000);
    send_leg(-338688000, 1512093000, 406413000, -739376000);
    send_leg(0, 0, -1, LON_MAX);
    send_leg(450000000, 100, -450000000, LON_MAX + 100);
    set_radius(23'd6000000);
    random_legs(300);
    set_radius(23'd7000000);
    random_legs(300);
    set_radius(23'd0);
    random_legs(100);
    set_radius(23'h7FFFFF);
    random_legs(300);
    set_radius(23'(6371000));
    // long result hold while items keep coming
    fork
      begin
        hold_long = 1;
        repeat (3 * LAT) @(posedge clk);
        hold_long = 0;
      end
      random_legs(200);
    join
    go_idle();
    random_legs(400);
    quiet = 1;
    random_legs(200);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("covered %0d results across five radius settings", checked);
    $display("including directed poles, antimeridian, wrap and coincident points");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
